// File: rtl/core/cli_pkg.sv
package cli_pkg;

    // Field widths of the item channels and the configuration port.
    localparam int unsigned READ_W  = 16;
    localparam int unsigned SCALE_W = 10;
    localparam int unsigned POS_W   = 14;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned WSUM_W  = 28;
    localparam int unsigned VSUM_W  = 14;
    localparam int unsigned PROD_W  = 14;

    // Shared bit-serial divider: numerator and step count.
    localparam int unsigned NUM_W     = 28;
    localparam int unsigned DIV_STEPS = 28;
    localparam int unsigned STEP_W    = 5;

    // Scaling and threshold constants.
    localparam logic [SCALE_W-1:0] FULL_SCALE  = 10'd1000;
    localparam logic [SCALE_W-1:0] SEEN_LEVEL  = 10'd200;
    localparam logic [SCALE_W-1:0] NOISE_LEVEL = 10'd100;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 5'd8;
    localparam logic [POS_W-1:0]   POS_MAX     = 14'd15000;

    // Configuration register indexes.
    localparam logic CFG_SENSOR_COUNT = 1'b0;
    localparam logic CFG_LIGHT_LINE   = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_SDIV  = 9'b000000100,
        ST_SCALE = 9'b000001000,
        ST_WEIGH = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_POS   = 9'b001000000,
        ST_PDIV  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    // x * 1000 as (x << 10) - (x << 4) - (x << 3).
    function automatic logic [NUM_W-1:0] times_thousand(input logic [NUM_W-1:0] x);
        times_thousand = (x << 10) - (x << 4) - (x << 3);
    endfunction

    // x * 500 as (x << 9) - (x << 3) - (x << 2).
    function automatic logic [POS_W-1:0] times_half_pitch(input logic [POS_W-1:0] x);
        times_half_pitch = (x << 9) - (x << 3) - (x << 2);
    endfunction

endpackage

// File: rtl/core/cli_in_if.sv
interface cli_in_if import cli_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [READ_W-1:0]  raw_reading;
    logic [READ_W-1:0]  cal_low;
    logic [READ_W-1:0]  cal_high;

    modport source (output valid, output raw_reading, output cal_low, output cal_high,
                    input ready);
    modport sink (input valid, input raw_reading, input cal_low, input cal_high,
                  output ready);
endinterface

// File: rtl/core/cli_out_if.sv
interface cli_out_if import cli_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] scaled_value;
    logic [POS_W-1:0]   line_position;
    logic               frame_done;

    modport source (output valid, output scaled_value, output line_position,
                    output frame_done, input ready);
    modport sink (input valid, input scaled_value, input line_position,
                  input frame_done, output ready);
endinterface

// File: rtl/core/calibrated_line_position.sv
// Calibrated line position over a reflectance sensor array.
// Input channel i_in: one item per sensor, sensor 0 first, carrying the raw
// reading and the sensor's calibration minimum and maximum. Output channel
// o_out: one item per input item with the scaled value 0..1000; the last
// sensor of a frame also carries the line position and frame_done.
// Configuration must be written through i_cfg_we / i_cfg_index / i_cfg_data
// only while the block is idle, which the block does not enforce: index 0 is
// the sensor count, index 1 the light-line flag. Each item runs through a
// sequencer around one shared restoring divider that retires one quotient bit
// per cycle over a 28-bit numerator. An ordinary sensor goes from acceptance
// through multiply, division, scaling, weighting and accumulation to the final
// state, which moves its result into the output register; a frame's last
// sensor also passes the position state and, when the line was seen, a second
// 28-step division for the weighted average. A new item is taken the cycle
// after the previous one has moved into the output register; a result may
// wait there while the next sensor is processed. If the receiver stalls and
// the output register is still full when the next result is ready, the
// sequencer holds that result and accepts nothing more. Synchronous reset
// empties the output register, clears the frame accumulators, sets the
// remembered position to the left edge and restores a sensor count of 8 with a dark line.
module calibrated_line_position import cli_pkg::*; #(
    parameter int unsigned MAX_SENSORS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    cli_in_if.sink           i_in,
    cli_out_if.source        o_out
);

    localparam int unsigned IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

    // Configuration and control registers.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_light;
    logic [IDX_W-1:0]   r_index, n_index;
    logic [WSUM_W-1:0]  r_wsum, n_wsum;
    logic [VSUM_W-1:0]  r_vsum, n_vsum;
    logic               r_seen, n_seen;
    logic [POS_W-1:0]   r_last_pos, n_last_pos;
    logic               r_out_valid, n_out_valid;

    // Per-item working registers.
    logic [READ_W-1:0]  r_diff, n_diff;
    logic [READ_W-1:0]  r_div, n_div;
    logic               r_zero, n_zero;
    logic               r_end, n_end;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [READ_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [SCALE_W-1:0] r_scaled, n_scaled;
    logic [SCALE_W-1:0] r_val, n_val;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_keep, n_keep;
    logic [POS_W-1:0]   r_pos, n_pos;

    // Output register payload.
    logic [SCALE_W-1:0] r_out_scaled, n_out_scaled;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic               r_out_done, n_out_done;

    logic [CNT_W-1:0]   act_count;
    logic [IDX_W-1:0]   last_idx;
    logic [READ_W:0]    rem_shift;
    logic               rem_ge;
    logic [READ_W:0]    rem_sub;
    logic               out_free;
    logic [POS_W-1:0]   half_span;

    // Active sensor count, clamped to 1..MAX_SENSORS.
    always_comb begin
        if (r_count == '0) begin
            act_count = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_SENSORS)) begin
            act_count = CNT_W'(MAX_SENSORS);
        end else begin
            act_count = r_count;
        end
    end
    assign last_idx  = IDX_W'(act_count - CNT_W'(1));
    assign half_span = times_half_pitch(POS_W'(last_idx));

    // One restoring division step.
    assign rem_shift = {r_rem, r_num[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_div};
    assign rem_sub   = rem_shift - {1'b0, r_div};

    assign out_free = !r_out_valid || o_out.ready;

    // Handshake and output drive.
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.scaled_value  = r_out_scaled;
    assign o_out.line_position = r_out_pos;
    assign o_out.frame_done    = r_out_done;

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_index      = r_index;
        n_wsum       = r_wsum;
        n_vsum       = r_vsum;
        n_seen       = r_seen;
        n_last_pos   = r_last_pos;
        n_diff       = r_diff;
        n_div        = r_div;
        n_zero       = r_zero;
        n_end        = r_end;
        n_num        = r_num;
        n_rem        = r_rem;
        n_step       = r_step;
        n_scaled     = r_scaled;
        n_val        = r_val;
        n_prod       = r_prod;
        n_keep       = r_keep;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_scaled = r_out_scaled;
        n_out_pos    = r_out_pos;
        n_out_done   = r_out_done;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_diff  = i_in.raw_reading - i_in.cal_low;
                    n_div   = i_in.cal_high - i_in.cal_low;
                    n_zero  = (i_in.cal_high == i_in.cal_low)
                              || (i_in.raw_reading < i_in.cal_low);
                    n_end   = (r_index >= last_idx);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_num   = times_thousand(NUM_W'(r_diff));
                n_rem   = '0;
                n_step  = '0;
                n_state = ST_SDIV;
            end
            ST_SDIV, ST_PDIV: begin
                n_rem  = rem_ge ? rem_sub[READ_W-1:0] : rem_shift[READ_W-1:0];
                n_num  = {r_num[NUM_W-2:0], rem_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = (r_state == ST_SDIV) ? ST_SCALE : ST_DONE;
                end
            end
            ST_SCALE: begin
                // Zero range or a reading below the minimum gives 0;
                // quotients past full scale saturate.
                if (r_zero) begin
                    n_scaled = '0;
                end else if (r_num > NUM_W'(FULL_SCALE)) begin
                    n_scaled = FULL_SCALE;
                end else begin
                    n_scaled = r_num[SCALE_W-1:0];
                end
                n_val   = r_light ? FULL_SCALE - n_scaled : n_scaled;
                n_state = ST_WEIGH;
            end
            ST_WEIGH: begin
                n_prod = PROD_W'(r_val) * PROD_W'(r_index);
                n_keep = (r_val > NOISE_LEVEL);
                if (r_val > SEEN_LEVEL) begin
                    n_seen = 1'b1;
                end
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_keep) begin
                    n_wsum = r_wsum + times_thousand(NUM_W'(r_prod));
                    n_vsum = r_vsum + VSUM_W'(r_val);
                end
                n_pos   = '0;
                n_state = r_end ? ST_POS : ST_DONE;
            end
            ST_POS: begin
                // Weighted average when the line was seen, else the edge
                // nearest the remembered position.
                if (r_seen && (r_vsum != '0)) begin
                    n_num   = r_wsum;
                    n_div   = READ_W'(r_vsum);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_PDIV;
                end else begin
                    n_pos   = (r_last_pos < half_span) ? '0 : POS_W'(half_span << 1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_scaled = r_scaled;
                    n_out_done   = r_end;
                    if (r_end) begin
                        // A position from the divider is its low bits.
                        n_out_pos  = (r_seen && (r_vsum != '0)) ? r_num[POS_W-1:0] : r_pos;
                        n_last_pos = n_out_pos;
                        n_index    = '0;
                        n_wsum     = '0;
                        n_vsum     = '0;
                        n_seen     = 1'b0;
                    end else begin
                        n_out_pos = '0;
                        n_index   = r_index + IDX_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_RESET;
            r_light     <= 1'b0;
            r_index     <= '0;
            r_wsum      <= '0;
            r_vsum      <= '0;
            r_seen      <= 1'b0;
            r_last_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_wsum      <= n_wsum;
            r_vsum      <= n_vsum;
            r_seen      <= n_seen;
            r_last_pos  <= n_last_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SENSOR_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                    CFG_LIGHT_LINE:   r_light <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_diff       <= n_diff;
        r_div        <= n_div;
        r_zero       <= n_zero;
        r_end        <= n_end;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_scaled     <= n_scaled;
        r_val        <= n_val;
        r_prod       <= n_prod;
        r_keep       <= n_keep;
        r_pos        <= n_pos;
        r_out_scaled <= n_out_scaled;
        r_out_pos    <= n_out_pos;
        r_out_done   <= n_out_done;
    end

    // A new result enters the output register only from the final state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared outside the final state");

    // Scaled values never pass full scale.
    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_scaled <= FULL_SCALE))
        else $error("scaled value above full scale");

    // Position is zero except on the last sensor, and bounded there.
    a_pos_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_pos == '0))
        else $error("position reported mid-frame");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pos <= POS_MAX))
        else $error("position beyond the array");

    // The divider never runs past its step count.
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SDIV || r_state == ST_PDIV) |-> (r_step < STEP_W'(DIV_STEPS)))
        else $error("divider step count overrun");

endmodule
